FILE: rtl/sas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg: shared types, constants and lookup functions
// Item, result and configuration structs plus the syscall classification tables.
// ----------------------------------------------------------------------------
package sas_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EVAL_MASK  = 2'd0;
  localparam logic [1:0] CFG_ALERT_THR  = 2'd1;
  localparam logic [1:0] CFG_DENY_THR   = 2'd2;

  // Configuration reset values.
  localparam logic [31:0] EVAL_MASK_RST = 32'h0000_007f;
  localparam logic [7:0]  ALERT_THR_RST = 8'd45;
  localparam logic [7:0]  DENY_THR_RST  = 8'd72;

  // Score arithmetic constants.
  localparam logic [6:0] SCORE_CAP      = 7'd100;
  localparam logic [4:0] WEIGHT_HIGH    = 5'd25;
  localparam logic [4:0] WEIGHT_LOW     = 5'd8;
  localparam logic [4:0] WEIGHT_NONE    = 5'd0;
  localparam logic [6:0] ALERT_BONUS    = 7'd10;
  localparam logic [6:0] EVAL_DECAY     = 7'd2;

  // Command codes.
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [9:0]  syscall_nr;
    logic [21:0] process_id;
    logic [63:0] generation;
  } item_t;

  typedef struct packed {
    logic        deny;
    logic        alert_raised;
    logic [6:0]  behav_score;
    logic [6:0]  pred_score;
    logic [31:0] alerts_total;
    logic [9:0]  last_suspect_nr;
    logic [21:0] last_suspect_pid;
  } result_t;

  typedef struct packed {
    logic [31:0] eval_mask;
    logic [7:0]  alert_thr;
    logic [7:0]  deny_thr;
  } cfg_t;

  // Benign syscalls that lower the behavior score.
  function automatic logic is_whitelisted(input logic [9:0] nr);
    logic hit;
    hit = 1'b0;
    if (nr <= 10'd3) hit = 1'b1;
    if (nr >= 10'd8 && nr <= 10'd12) hit = 1'b1;
    if (nr == 10'd16) hit = 1'b1;
    if (nr >= 10'd21 && nr <= 10'd25) hit = 1'b1;
    if (nr == 10'd32 || nr == 10'd39) hit = 1'b1;
    if (nr >= 10'd41 && nr <= 10'd47) hit = 1'b1;
    if (nr >= 10'd202 && nr <= 10'd204) hit = 1'b1;
    if (nr == 10'd228 || nr == 10'd230 || nr == 10'd231) hit = 1'b1;
    return hit;
  endfunction

  // Score weight of a suspicious syscall; zero for neutral numbers.
  function automatic logic [4:0] suspect_weight(input logic [9:0] nr);
    logic [4:0] w;
    case (nr)
      10'd101, 10'd155, 10'd157, 10'd165, 10'd174, 10'd175, 10'd250,
      10'd272, 10'd298, 10'd310, 10'd311, 10'd313, 10'd319, 10'd321: begin
        w = WEIGHT_HIGH;
      end
      10'd56, 10'd59, 10'd41: begin
        w = WEIGHT_LOW;
      end
      default: begin
        w = WEIGHT_NONE;
      end
    endcase
    return w;
  endfunction

  // Add with saturation at the score cap.
  function automatic logic [6:0] sat_add(input logic [6:0] a, input logic [6:0] b);
    logic [7:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, SCORE_CAP}) ? SCORE_CAP : s[6:0];
  endfunction

endpackage

FILE: rtl/sas_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_score: scoring state and next-result logic
// Holds the scores, alert count and last suspect; computes one result per item.
// ----------------------------------------------------------------------------
module sas_score (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  sas_pkg::item_t   item,
  input  sas_pkg::cfg_t    cfg,
  output sas_pkg::result_t res
);

  logic [6:0]  behavior_r, behavior_nxt;
  logic [6:0]  predictive_r, predictive_nxt;
  logic [31:0] alerts_r, alerts_nxt;
  logic [9:0]  suspect_nr_r, suspect_nr_nxt;
  logic [21:0] suspect_pid_r, suspect_pid_nxt;

  logic        on_boundary;
  logic        white;
  logic [4:0]  weight;
  logic        alert;
  logic        deny;
  logic [6:0]  pred_alerted;

  // Classification of the current item.
  assign on_boundary = (item.generation & {32'd0, cfg.eval_mask}) == 64'd0;
  assign white       = sas_pkg::is_whitelisted(item.syscall_nr);
  assign weight      = sas_pkg::suspect_weight(item.syscall_nr);

  // Evaluation decisions.
  assign alert        = (item.command == sas_pkg::CMD_EVAL) && on_boundary &&
                        ({1'b0, behavior_r} >= cfg.alert_thr);
  assign pred_alerted = alert ? sas_pkg::sat_add(predictive_r, sas_pkg::ALERT_BONUS)
                              : predictive_r;
  assign deny         = (item.command == sas_pkg::CMD_EVAL) && on_boundary &&
                        ({1'b0, pred_alerted} >= cfg.deny_thr);

  // Next state for events and evaluations.
  always_comb begin
    behavior_nxt    = behavior_r;
    predictive_nxt  = predictive_r;
    alerts_nxt      = alerts_r;
    suspect_nr_nxt  = suspect_nr_r;
    suspect_pid_nxt = suspect_pid_r;
    if (item.command == sas_pkg::CMD_EVENT) begin
      if (white) begin
        if (behavior_r != 7'd0) behavior_nxt = behavior_r - 7'd1;
      end else begin
        if (weight != sas_pkg::WEIGHT_NONE) begin
          behavior_nxt    = sas_pkg::sat_add(behavior_r, {2'b00, weight});
          suspect_nr_nxt  = item.syscall_nr;
          suspect_pid_nxt = item.process_id;
        end
        if (item.generation != 64'd0 && on_boundary) begin
          predictive_nxt = sas_pkg::sat_add(predictive_r, {4'd0, weight[4:2]});
        end
      end
    end else if (on_boundary) begin
      if (alert) alerts_nxt = alerts_r + 32'd1;
      predictive_nxt = pred_alerted;
      if (!deny) begin
        behavior_nxt   = (behavior_r >= sas_pkg::EVAL_DECAY) ?
                         behavior_r - sas_pkg::EVAL_DECAY : 7'd0;
        if (pred_alerted != 7'd0) predictive_nxt = pred_alerted - 7'd1;
      end
    end
  end

  // State registers move once per transfer out of the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      behavior_r    <= 7'd0;
      predictive_r  <= 7'd0;
      alerts_r      <= 32'd0;
      suspect_nr_r  <= 10'd0;
      suspect_pid_r <= 22'd0;
    end else if (advance) begin
      behavior_r    <= behavior_nxt;
      predictive_r  <= predictive_nxt;
      alerts_r      <= alerts_nxt;
      suspect_nr_r  <= suspect_nr_nxt;
      suspect_pid_r <= suspect_pid_nxt;
    end
  end

  // Result reflects the state after this item.
  always_comb begin
    res.deny             = deny;
    res.alert_raised     = alert;
    res.behav_score      = behavior_nxt;
    res.pred_score       = predictive_nxt;
    res.alerts_total     = alerts_nxt;
    res.last_suspect_nr  = suspect_nr_nxt;
    res.last_suspect_pid = suspect_pid_nxt;
  end

endmodule

FILE: rtl/sas_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_out_reg: result register
// Holds one finished result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module sas_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sas_pkg::result_t res_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_stall,
  output sas_pkg::result_t res_out
);

  logic             valid_r, valid_nxt;
  sas_pkg::result_t data_r;

  // The register frees up in the same cycle its content is taken.
  assign can_load  = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = data_r;

endmodule

FILE: rtl/syscall_anomaly_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// syscall_anomaly_scorer: behavior and predictive scoring of syscall events
// Input register, combinational scoring logic, and a result register.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_stall   command, syscall_nr, process_id, generation
//  out_     output     out_valid / out_stall deny ... last_suspect_pid
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low. A result goes through the
// input register, then the result register, before out_valid shows it.
// The scoring state registers update as each item leaves the input register.
// Synchronous active-low reset clears scores, counters and config to defaults.
// A stalled output holds its result; the input stage then fills and stalls.
module syscall_anomaly_scorer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [9:0]  in_syscall_nr,
  input  logic [21:0] in_process_id,
  input  logic [63:0] in_generation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_deny,
  output logic        out_alert_raised,
  output logic [6:0]  out_behav_score,
  output logic [6:0]  out_pred_score,
  output logic [31:0] out_alerts_total,
  output logic [9:0]  out_last_suspect_nr,
  output logic [21:0] out_last_suspect_pid,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  sas_pkg::cfg_t    cfg_r;
  sas_pkg::item_t   item_r;
  logic             item_valid_r, item_valid_nxt;
  logic             advance;
  logic             can_load;
  logic             in_take;
  sas_pkg::result_t res_next;
  sas_pkg::result_t res_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.eval_mask <= sas_pkg::EVAL_MASK_RST;
      cfg_r.alert_thr <= sas_pkg::ALERT_THR_RST;
      cfg_r.deny_thr  <= sas_pkg::DENY_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sas_pkg::CFG_EVAL_MASK: cfg_r.eval_mask <= cfg_wdata;
        sas_pkg::CFG_ALERT_THR: cfg_r.alert_thr <= cfg_wdata[7:0];
        sas_pkg::CFG_DENY_THR:  cfg_r.deny_thr  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage: an item moves on when the result register can load.
  assign advance        = item_valid_r && can_load;
  assign in_stall       = item_valid_r && !can_load;
  assign in_take        = in_valid && !in_stall;
  assign item_valid_nxt = in_take ? 1'b1 : (item_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.command    <= in_command;
      item_r.syscall_nr <= in_syscall_nr;
      item_r.process_id <= in_process_id;
      item_r.generation <= in_generation;
    end
  end

  // Scoring logic and state.
  sas_score u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res_next)
  );

  // Result register.
  sas_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (res_next),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign out_deny             = res_q.deny;
  assign out_alert_raised     = res_q.alert_raised;
  assign out_behav_score      = res_q.behav_score;
  assign out_pred_score       = res_q.pred_score;
  assign out_alerts_total     = res_q.alerts_total;
  assign out_last_suspect_nr  = res_q.last_suspect_nr;
  assign out_last_suspect_pid = res_q.last_suspect_pid;

endmodule
